// File: rtl/ab_pkg.sv
// ----------------------------------------------------------------------------
// ab_pkg - allocation bitmap shared definitions
// Operation codes, request and result layouts and register constants.
// ----------------------------------------------------------------------------
package ab_pkg;

	// operation codes carried in the request
	localparam logic [1:0] OP_WRITE_BIT = 2'd0;
	localparam logic [1:0] OP_TEST_BIT  = 2'd1;
	localparam logic [1:0] OP_FILL      = 2'd2;
	localparam logic [1:0] OP_FIND_ZERO = 2'd3;

	// field widths
	localparam int unsigned OP_W    = 2;
	localparam int unsigned INDEX_W = 10;
	localparam int unsigned CFG_W   = 11;

	// register map, one register at byte offset 0
	localparam int unsigned  PADDR_W         = 3;
	localparam logic [0:0]   REG_BITS_IN_USE = 1'b0;
	localparam logic [10:0]  BITS_IN_USE_RST = 11'd1024;

	// request layout, last field in the lowest bits
	typedef struct packed {
		logic               bit_value;
		logic [INDEX_W-1:0] bit_index;
		logic [OP_W-1:0]    op;
	} cmd_t;

	// result layout, last field in the lowest bits
	typedef struct packed {
		logic               none_free;
		logic [INDEX_W-1:0] free_index;
		logic               tested_bit;
	} result_t;

	localparam int unsigned CMD_PAD = 16 - $bits(cmd_t);
	localparam int unsigned RES_PAD = 16 - $bits(result_t);

endpackage

// File: rtl/ab_ram.sv
// ----------------------------------------------------------------------------
// ab_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle, no reset on the contents.
// ----------------------------------------------------------------------------
module ab_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 32
) (
	input  logic                                clk,
	input  logic                                we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                    wdata,
	input  logic                                re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                    rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/allocation_bitmap.sv
// ----------------------------------------------------------------------------
// allocation_bitmap - allocation bitmap with find-first-zero search
// Bits live in a word RAM; every request is handled by a read-modify-write
// engine that walks the words one per cycle.
// ----------------------------------------------------------------------------
// Usage
//   s_* stream takes one request per item: op, bit_index, bit_value.
//   m_* stream gives exactly one result per request: tested_bit, free_index,
//   none_free. Results come out in request order.
//   APB port holds bits_in_use at offset 0; write it only while idle.
// Timing
//   write_bit and test_bit touch at most the one word that holds bit_index.
//   fill and find_first_zero walk the words up to bits_in_use (at most
//   MAX_BITS); the search stops at the first word with a free bit. The word
//   RAM gives one read and one write per cycle, so the walk advances one
//   word per cycle.
//   One request is worked on at a time; the next one is taken while the
//   previous result still waits in the output register.
// Reset
//   all bits read as zero after reset (per-word valid flags), bits_in_use
//   returns to 1024. A stalled receiver holds the result and, once the
//   following request is done, holds off further requests.
//   WORD_BITS must be a power of two.
// ----------------------------------------------------------------------------
module allocation_bitmap import ab_pkg::*; #(
	parameter int unsigned MAX_BITS  = 1024,
	parameter int unsigned WORD_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	// request: [1:0] op, [11:2] bit_index, [12] bit_value, [15:13] zero
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [15:0]        s_tdata,
	// result: [0] tested_bit, [10:1] free_index, [11] none_free, [15:12] zero
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [15:0]        m_tdata,
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int unsigned WORD_COUNT = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int unsigned AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int unsigned OW = $clog2(WORD_BITS);
	localparam int unsigned BW0 = $clog2(WORD_COUNT * WORD_BITS + 1);
	localparam int unsigned BW = (BW0 > CFG_W) ? BW0 : CFG_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]           state_q;
	logic [CFG_W-1:0]     bits_in_use_q;
	logic [OP_W-1:0]      op_q;
	logic [INDEX_W-1:0]   idx_q;
	logic                 val_q;
	logic [BW-1:0]        lim_q;
	logic [AW-1:0]        iss_word_q;
	logic [BW-1:0]        iss_base_q;
	logic                 iss_stop_q;
	logic                 rd_v_s1;
	logic [AW-1:0]        word_s1;
	logic [BW-1:0]        base_s1;
	logic                 res_tested_q;
	logic [BW-1:0]        res_free_q;
	logic                 res_none_q;
	logic                 m_tvalid_q;
	result_t              m_res_q;
	logic [WORD_COUNT-1:0] valid_q;

	cmd_t                 cmd;
	logic                 accept;
	logic                 single;
	logic [BW-1:0]        cfg_ext;
	logic [BW-1:0]        lim_now;
	logic                 iss_more;
	logic                 iss_en;
	logic [WORD_BITS-1:0] rdata;
	logic [WORD_BITS-1:0] word_cur;
	logic [WORD_BITS-1:0] word_new;
	logic [WORD_BITS-1:0] use_mask;
	logic [WORD_BITS-1:0] zero_map;
	logic [BW-1:0]        rem;
	logic [OW-1:0]        bit_pos;
	logic [OW-1:0]        zero_pos;
	logic [OW-1:0]        zero_off;
	logic                 zero_hit;
	logic                 found;
	logic                 ram_we;
	logic                 finish;
	logic                 load;
	logic                 cfg_wr;

	// configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2:2] == REG_BITS_IN_USE);
	assign prdata = (paddr[2:2] == REG_BITS_IN_USE) ?
		{{(32 - CFG_W){1'b0}}, bits_in_use_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_in_use_q <= BITS_IN_USE_RST;
		end else if (cfg_wr) begin
			bits_in_use_q <= pwdata[CFG_W-1:0];
		end
	end

	// request decode and bound
	assign cmd      = s_tdata[$bits(cmd_t)-1:0];
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign single   = (cmd.op == OP_WRITE_BIT) || (cmd.op == OP_TEST_BIT);
	assign cfg_ext  = BW'(bits_in_use_q);
	assign lim_now  = (cfg_ext > BW'(MAX_BITS)) ? BW'(MAX_BITS) : cfg_ext;

	// read issue
	assign iss_more = !iss_stop_q && (iss_base_q < lim_q);
	assign iss_en   = (state_q == ST_RUN) && iss_more;

	ab_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (WORD_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (word_s1),
		.wdata (word_new),
		.re    (iss_en),
		.raddr (iss_word_q),
		.rdata (rdata)
	);

	// word seen by the data stage, unwritten words read as zero
	assign word_cur = valid_q[word_s1] ? rdata : '0;
	assign rem      = lim_q - base_s1;
	assign bit_pos  = ~idx_q[OW-1:0];

	// in-use bits of the current word, lowest index at the msb
	always_comb begin
		for (int p = 0; p < WORD_BITS; p++) begin
			use_mask[p] = (BW'(WORD_BITS - 1 - p) < rem);
		end
	end

	assign zero_map = ~word_cur & use_mask;

	// leading free bit, highest position wins
	always_comb begin
		zero_hit = 1'b0;
		zero_pos = '0;
		for (int p = 0; p < WORD_BITS; p++) begin
			if (zero_map[p]) begin
				zero_hit = 1'b1;
				zero_pos = OW'(p);
			end
		end
	end

	// offset of the free bit from the start of its word
	assign zero_off = ~zero_pos;

	// modified word for write_bit and fill
	always_comb begin
		word_new = word_cur;
		case (op_q)
			OP_WRITE_BIT: word_new[bit_pos] = val_q;
			OP_FILL:      word_new = (word_cur & ~use_mask) | (val_q ? use_mask : '0);
			default:      word_new = word_cur;
		endcase
	end

	assign ram_we = (state_q == ST_RUN) && rd_v_s1 &&
		((op_q == OP_WRITE_BIT) || (op_q == OP_FILL));
	assign found  = (state_q == ST_RUN) && rd_v_s1 && (op_q == OP_FIND_ZERO) && zero_hit;
	assign finish = (state_q == ST_RUN) && (found || (!rd_v_s1 && !iss_more));
	assign load   = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	// control sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_v_s1 <= 1'b0;
			valid_q <= '0;
		end else begin
			rd_v_s1 <= iss_en;
			if (ram_we) begin
				valid_q[word_s1] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_RUN;
				ST_RUN:  if (finish) state_q <= ST_DONE;
				ST_DONE: if (load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request registers, walk counters and result accumulation
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q         <= cmd.op;
			idx_q        <= cmd.bit_index;
			val_q        <= cmd.bit_value;
			lim_q        <= lim_now;
			iss_word_q   <= single ? AW'(cmd.bit_index >> OW) : '0;
			iss_base_q   <= single ? (BW'(cmd.bit_index) & ~BW'(WORD_BITS - 1)) : '0;
			iss_stop_q   <= single && (BW'(cmd.bit_index) >= lim_now);
			res_tested_q <= 1'b0;
			res_free_q   <= '0;
			res_none_q   <= (cmd.op == OP_FIND_ZERO);
		end else begin
			if (iss_en) begin
				iss_word_q <= iss_word_q + AW'(1);
				iss_base_q <= iss_base_q + BW'(WORD_BITS);
				if ((op_q == OP_WRITE_BIT) || (op_q == OP_TEST_BIT)) begin
					iss_stop_q <= 1'b1;
				end
			end
			if ((state_q == ST_RUN) && rd_v_s1 && (op_q == OP_TEST_BIT)) begin
				res_tested_q <= word_cur[bit_pos];
			end
			if (found) begin
				res_free_q <= base_s1 + BW'(zero_off);
				res_none_q <= 1'b0;
			end
		end
		word_s1 <= iss_word_q;
		base_s1 <= iss_base_q;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_res_q.tested_bit <= res_tested_q;
			m_res_q.free_index <= res_free_q[INDEX_W-1:0];
			m_res_q.none_free  <= res_none_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{RES_PAD{1'b0}}, m_res_q};

	// data stage is empty whenever a request can be taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !rd_v_s1)
		else $error("read in flight while idle");

	// writes stay inside the word store
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (32'(word_s1) < WORD_COUNT))
		else $error("write beyond word store");

	// a reported free bit lies inside the bits in use
	assert property (@(posedge clk) disable iff (!arst_n)
		(load && (op_q == OP_FIND_ZERO) && !res_none_q) |-> (res_free_q < lim_q))
		else $error("free index beyond bits in use");

	// an accepted request always starts the walk
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_RUN))
		else $error("accepted request not started");

endmodule
